### design/obdrsp_pkg.sv
`default_nettype none

package obdrsp_pkg;

  // Response id window and frame length limits
  localparam logic [10:0] ID_LO        = 11'h7E8;
  localparam logic [10:0] ID_HI        = 11'h7EF;
  localparam logic [3:0]  MAX_DATA_LEN = 4'd8;
  localparam logic [3:0]  MIN_RESP_LEN = 4'd3;

  // Protocol control information: high nibble is the frame type
  localparam logic [3:0]  PCI_SINGLE   = 4'h0;

  // Service and parameter codes
  localparam logic [7:0]  SVC_CUR_DATA    = 8'h41;
  localparam logic [7:0]  SVC_STORED_DTC  = 8'h43;
  localparam logic [7:0]  PID_STATUS      = 8'h01;
  localparam logic [7:0]  PID_MODULE_VOLT = 8'h42;

  // Default width of the response counter
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  typedef struct packed {
    logic [10:0] can_id;
    logic [3:0]  frame_len;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
  } in_t;

  typedef struct packed {
    logic        frame_taken;
    logic        diag_seen;
    logic [15:0] response_count;
    logic [10:0] source_id;
    logic [7:0]  service_id;
    logic [7:0]  pid_value;
    logic        lamp_on;
    logic        lamp_known;
    logic [6:0]  fault_count;
    logic [15:0] supply_mv;
    logic        supply_known;
  } out_t;

  // Decoded status kept across frames (counter held apart, its width varies)
  typedef struct packed {
    logic        seen;
    logic [10:0] source;
    logic [7:0]  service;
    logic [7:0]  pid;
    logic        lamp_on;
    logic        lamp_known;
    logic [6:0]  fault;
    logic [15:0] volt_mv;
    logic        volt_known;
  } status_t;

endpackage

`default_nettype wire

### design/obd_response_frame_parser_core.sv
`default_nettype none

// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  in_data_i  (obdrsp_pkg::in_t)
// out      output     out_valid_o / out_stall_i out_data_o (obdrsp_pkg::out_t)
//
// One frame per cycle sustained while out_stall_i is low; a frame waits in the input
// register and its result is loaded into the result register once that one is free,
// so it is presented after passing through both registers. The status registers update
// at that same edge.
// Reset clears all status, the counter and both valid flags.
// A stalled result holds; the input register still takes one more frame.

module obd_response_frame_parser_core #(
  parameter int unsigned COUNT_WIDTH = obdrsp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  obdrsp_pkg::in_t     in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output obdrsp_pkg::out_t    out_data_o
);

  logic                   in_valid_q, in_valid_d;
  obdrsp_pkg::in_t        in_q;
  logic                   out_valid_q, out_valid_d;
  obdrsp_pkg::out_t       out_q, out_d;
  obdrsp_pkg::status_t    status_q, status_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   taken;
  logic                   out_free;
  logic                   adv;
  logic                   in_take;

  // Handshake and advance control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take ? 1'b1 : (adv ? 1'b0 : in_valid_q);
  assign out_valid_d = out_free ? in_valid_q : out_valid_q;

  obdrsp_decode #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_decode (
    .frame_i  (in_q),
    .status_i (status_q),
    .count_i  (cnt_q),
    .taken_o  (taken),
    .status_o (status_d),
    .count_o  (cnt_d)
  );

  // Build the result from the updated status
  always_comb begin
    out_d.frame_taken    = taken;
    out_d.diag_seen      = status_d.seen;
    out_d.response_count = 16'(cnt_d);
    out_d.source_id      = status_d.source;
    out_d.service_id     = status_d.service;
    out_d.pid_value      = status_d.pid;
    out_d.lamp_on        = status_d.lamp_on;
    out_d.lamp_known     = status_d.lamp_known;
    out_d.fault_count    = status_d.fault;
    out_d.supply_mv      = status_d.volt_mv;
    out_d.supply_known   = status_d.volt_known;
  end

  // Control and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      cnt_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        status_q <= status_d;
        cnt_q    <= cnt_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The counter moves only when a taken frame advances
  a_cnt_moves_on_taken : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> $past(adv && taken))
    else $error("response counter changed without a taken frame");

  // A taken result always reports the seen flag
  a_taken_seen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_taken |-> out_q.diag_seen)
    else $error("taken frame without seen flag");

  // Once the lamp status is known it stays known
  a_lamp_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q.lamp_known |=> status_q.lamp_known)
    else $error("lamp status lost");

  // A recorded source always lies in the response id window
  a_source_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q.seen |-> (status_q.source >= obdrsp_pkg::ID_LO &&
                       status_q.source <= obdrsp_pkg::ID_HI))
    else $error("recorded source outside the response window");

endmodule

`default_nettype wire

### design/obdrsp_decode.sv
`default_nettype none

module obdrsp_decode #(
  parameter int unsigned COUNT_WIDTH = obdrsp_pkg::COUNT_WIDTH_DEF
) (
  input  obdrsp_pkg::in_t         frame_i,
  input  obdrsp_pkg::status_t     status_i,
  input  logic [COUNT_WIDTH-1:0]  count_i,
  output logic                    taken_o,
  output obdrsp_pkg::status_t     status_o,
  output logic [COUNT_WIDTH-1:0]  count_o
);

  logic [3:0] len;
  logic [3:0] plen;
  logic       single;
  logic [1:0] dtc_n;

  // Clamp the length to the eight data bytes that exist
  assign len = (frame_i.frame_len > obdrsp_pkg::MAX_DATA_LEN) ?
               obdrsp_pkg::MAX_DATA_LEN : frame_i.frame_len;
  assign plen   = frame_i.byte0[3:0];
  assign single = (frame_i.byte0[7:4] == obdrsp_pkg::PCI_SINGLE);

  // Count nonzero code pairs that lie fully inside the frame
  always_comb begin
    dtc_n = 2'd0;
    if (len >= 4'd4 && (frame_i.byte2 != 8'h00 || frame_i.byte3 != 8'h00)) begin
      dtc_n = dtc_n + 2'd1;
    end
    if (len >= 4'd6 && (frame_i.byte4 != 8'h00 || frame_i.byte5 != 8'h00)) begin
      dtc_n = dtc_n + 2'd1;
    end
    if (len >= 4'd8 && (frame_i.byte6 != 8'h00 || frame_i.byte7 != 8'h00)) begin
      dtc_n = dtc_n + 2'd1;
    end
  end

  // Accept the frame, then decode a single-frame payload
  always_comb begin
    status_o = status_i;
    count_o  = count_i;
    taken_o  = (frame_i.can_id inside {[obdrsp_pkg::ID_LO:obdrsp_pkg::ID_HI]}) &&
               (len >= obdrsp_pkg::MIN_RESP_LEN);
    if (taken_o) begin
      status_o.seen   = 1'b1;
      status_o.source = frame_i.can_id;
      count_o         = count_i + COUNT_WIDTH'(1);
      if (single && plen >= 4'd1) begin
        status_o.service = frame_i.byte1;
        status_o.pid     = (plen >= 4'd2) ? frame_i.byte2 : 8'h00;
        if (frame_i.byte1 == obdrsp_pkg::SVC_CUR_DATA && plen >= 4'd2) begin
          if (frame_i.byte2 == obdrsp_pkg::PID_STATUS && plen >= 4'd6 && len >= 4'd6) begin
            status_o.lamp_on    = frame_i.byte3[7];
            status_o.lamp_known = 1'b1;
            status_o.fault      = frame_i.byte3[6:0];
          end else if (frame_i.byte2 == obdrsp_pkg::PID_MODULE_VOLT &&
                       plen >= 4'd4 && len >= 4'd5) begin
            status_o.volt_mv    = {frame_i.byte3, frame_i.byte4};
            status_o.volt_known = 1'b1;
          end
        end else if (frame_i.byte1 == obdrsp_pkg::SVC_STORED_DTC) begin
          status_o.fault      = 7'(dtc_n);
          status_o.lamp_known = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire
